/* sv/pcpa_pkg.sv */
package pcpa_pkg;

  localparam int DEF_NUM_CHANNELS = 1024;
  localparam int DEF_MAX_TERMS    = 4;

  localparam int REQ_W    = 2;
  localparam int CHAN_W   = 10;
  localparam int TIDX_W   = 2;
  localparam int COEF_W   = 32;
  localparam int TCNT_W   = 3;
  localparam int CHARGE_W = 32;
  localparam int ACC_W    = 48;

  localparam int FRAC_W = 16;
  localparam int HALF_W = ACC_W / 2;
  localparam int PROD_W = HALF_W + CHARGE_W;
  localparam int SUM_W  = PROD_W + HALF_W - FRAC_W;
  localparam int MSUM_W = 50;
  localparam int TSUM_W = MSUM_W + 2;

  localparam logic [REQ_W-1:0] REQ_EVAL  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_COEF  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_COUNT = 2'd2;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [MSUM_W-1:0] M_LIMIT = {1'b1, {(MSUM_W-1){1'b0}}};

  typedef enum logic [2:0] {
    MAC_NOP,
    MAC_ZERO,
    MAC_LOAD,
    MAC_MAG,
    MAC_MULH,
    MAC_MULL,
    MAC_COMB,
    MAC_ADD
  } mac_op_t;

  typedef struct packed {
    mac_op_t op;
    logic    q_neg;
  } mac_ctrl_t;

endpackage

/* sv/pcpa_if.sv */
interface pcpa_in_if import pcpa_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [REQ_W-1:0]           req_type;
  logic [CHAN_W-1:0]          channel;
  logic [TIDX_W-1:0]          term_index;
  logic signed [COEF_W-1:0]   coefficient;
  logic [TCNT_W-1:0]          term_count;
  logic signed [CHARGE_W-1:0] charge;

  modport source (
    output valid, req_type, channel, term_index, coefficient, term_count, charge,
    input  ready
  );
  modport sink (
    input  valid, req_type, channel, term_index, coefficient, term_count, charge,
    output ready
  );
endinterface

interface pcpa_out_if import pcpa_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [ACC_W-1:0] aligned_charge;
  logic                    saturated;

  modport source (
    output valid, aligned_charge, saturated,
    input  ready
  );
  modport sink (
    input  valid, aligned_charge, saturated,
    output ready
  );
endinterface

/* sv/pcpa_coef_mem.sv */
module pcpa_coef_mem import pcpa_pkg::*; #(
  parameter int ADDR_W = 12,
  parameter int DEPTH  = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [ADDR_W-1:0]        waddr,
  input  logic signed [COEF_W-1:0] wdata,
  input  logic [ADDR_W-1:0]        raddr,
  output logic signed [COEF_W-1:0] rdata
);

  logic signed [COEF_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/pcpa_count_mem.sv */
module pcpa_count_mem import pcpa_pkg::*; #(
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
  parameter int ADDR_W       = 10,
  parameter int DATA_W       = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata,
  output logic              clear_done
);

  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(NUM_CHANNELS - 1);

  logic [DATA_W-1:0] mem [NUM_CHANNELS];
  logic              clearing;
  logic [ADDR_W-1:0] clr_idx;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [DATA_W-1:0] mem_data;

  // After reset every entry is swept to zero, one a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + ADDR_W'(1);
      if (clr_idx == LAST) begin
        clearing <= 1'b0;
      end
    end
  end

  always_comb begin
    mem_we   = clearing || we;
    mem_addr = clearing ? clr_idx : waddr;
    mem_data = clearing ? '0 : wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_data;
    end
    rdata <= mem[raddr];
  end

  assign clear_done = !clearing;

endmodule

/* sv/pcpa_mac.sv */
module pcpa_mac import pcpa_pkg::*; (
  input  logic                     clk,
  input  mac_ctrl_t                ctrl,
  input  logic [CHARGE_W-1:0]      q_mag,
  input  logic signed [COEF_W-1:0] coef,
  output logic signed [ACC_W-1:0]  acc,
  output logic                     sat
);

  logic [ACC_W-1:0]          a_mag;
  logic                      p_neg;
  logic [PROD_W-1:0]         p_hi;
  logic [PROD_W-1:0]         p_lo;
  logic [MSUM_W-1:0]         m;
  logic [HALF_W-1:0]         mul_a;
  logic [PROD_W-1:0]         prod;
  logic [SUM_W-1:0]          sum;
  logic signed [TSUM_W-1:0]  m_ext;
  logic signed [TSUM_W-1:0]  t;
  logic                      in_range;

  // One shared multiplier serves both halves of the accumulator magnitude.
  always_comb begin
    mul_a = (ctrl.op == MAC_MULH) ? a_mag[ACC_W-1:HALF_W] : a_mag[HALF_W-1:0];
    prod  = {{CHARGE_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, q_mag};
    sum   = {p_hi, {(HALF_W-FRAC_W){1'b0}}} + {{HALF_W{1'b0}}, p_lo[PROD_W-1:FRAC_W]};
    m_ext = {2'b00, m};
    t     = (p_neg ? -m_ext : m_ext) + {{(TSUM_W-COEF_W){coef[COEF_W-1]}}, coef};
    in_range = (&t[TSUM_W-1:ACC_W-1]) || !(|t[TSUM_W-1:ACC_W-1]);
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      MAC_NOP: begin
      end
      MAC_ZERO: begin
        acc <= '0;
        sat <= 1'b0;
      end
      MAC_LOAD: begin
        acc <= {{(ACC_W-COEF_W){coef[COEF_W-1]}}, coef};
      end
      MAC_MAG: begin
        a_mag <= acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
        p_neg <= acc[ACC_W-1] ^ ctrl.q_neg;
      end
      MAC_MULH: begin
        p_hi <= prod;
      end
      MAC_MULL: begin
        p_lo <= prod;
      end
      MAC_COMB: begin
        m <= (sum > SUM_W'(M_LIMIT)) ? M_LIMIT : sum[MSUM_W-1:0];
      end
      MAC_ADD: begin
        if (in_range) begin
          acc <= t[ACC_W-1:0];
        end else begin
          acc <= t[TSUM_W-1] ? ACC_MIN : ACC_MAX;
          sat <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* sv/per_channel_polynomial_alignment_unit.sv */
// Channel  Dir  Word
// item     in   req_type, channel, term_index, coefficient, term_count, charge
// result   out  aligned_charge, saturated
//
// A write word leaves the unit idle. An evaluate word for a channel in range reads its term
// count, loads the top coefficient, then runs a Horner step per further term on the shared
// multiply-add unit through the MAG, MULH, MULL, COMB and ADD states; with no terms, or out
// of range, it goes to the done state. After reset the term count memory is cleared, during
// which no word is taken. A finished result waits in the output register while later words
// are taken; the next evaluate then stalls in its done state until that result has left.
module per_channel_polynomial_alignment_unit import pcpa_pkg::*; #(
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
  parameter int MAX_TERMS    = DEF_MAX_TERMS
) (
  input logic       clk,
  input logic       rst,
  pcpa_in_if.sink   item,
  pcpa_out_if.source result
);

  localparam int CH_AW      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int TI_AW      = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W      = $clog2(MAX_TERMS + 1);
  localparam int COEF_AW    = CH_AW + TI_AW;
  localparam int COEF_DEPTH = NUM_CHANNELS * (2 ** TI_AW);

  typedef enum logic [3:0] {
    S_IDLE,
    S_COUNT,
    S_LOAD,
    S_MAG,
    S_MULH,
    S_MULL,
    S_COMB,
    S_ADD,
    S_DONE
  } state_t;

  state_t                   state;
  logic [TI_AW-1:0]         k;
  logic [CH_AW-1:0]         ch_q;
  logic [CHARGE_W-1:0]      q_mag;
  logic                     q_neg;

  logic                     accept;
  logic                     res_load;
  logic                     ch_ok;
  logic [CH_AW-1:0]         ch_addr;
  logic [CNT_W-1:0]         tc_clamped;
  logic                     cnt_we;
  logic [CNT_W-1:0]         tc_rdata;
  logic                     clear_done;
  logic                     coef_we;
  logic [COEF_AW-1:0]       coef_waddr;
  logic [COEF_AW-1:0]       coef_raddr;
  logic signed [COEF_W-1:0] coef_rdata;
  logic [TI_AW-1:0]         top_k;
  mac_ctrl_t                mac_ctrl;
  logic signed [ACC_W-1:0]  mac_acc;
  logic                     mac_sat;

  assign item.ready = (state == S_IDLE) && clear_done;
  assign accept     = item.valid && item.ready;
  assign res_load   = (state == S_DONE) && (!result.valid || result.ready);

  always_comb begin
    ch_ok      = 32'(item.channel) < NUM_CHANNELS;
    ch_addr    = CH_AW'(item.channel);
    tc_clamped = (32'(item.term_count) > MAX_TERMS) ? CNT_W'(MAX_TERMS)
                                                    : CNT_W'(item.term_count);
    cnt_we     = accept && (item.req_type == REQ_COUNT) && ch_ok;
    coef_we    = accept && (item.req_type == REQ_COEF) && ch_ok
                 && (32'(item.term_index) < MAX_TERMS);
    coef_waddr = {ch_addr, TI_AW'(item.term_index)};
    top_k      = TI_AW'(tc_rdata - CNT_W'(1));
    coef_raddr = (state == S_COUNT) ? {ch_q, top_k} : {ch_q, k};
  end

  always_comb begin
    mac_ctrl.q_neg = q_neg;
    unique case (state)
      S_IDLE:  mac_ctrl.op = (accept && (item.req_type == REQ_EVAL)) ? MAC_ZERO : MAC_NOP;
      S_LOAD:  mac_ctrl.op = MAC_LOAD;
      S_MAG:   mac_ctrl.op = MAC_MAG;
      S_MULH:  mac_ctrl.op = MAC_MULH;
      S_MULL:  mac_ctrl.op = MAC_MULL;
      S_COMB:  mac_ctrl.op = MAC_COMB;
      S_ADD:   mac_ctrl.op = MAC_ADD;
      default: mac_ctrl.op = MAC_NOP;
    endcase
  end

  pcpa_count_mem #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .ADDR_W       (CH_AW),
    .DATA_W       (CNT_W)
  ) u_count_mem (
    .clk        (clk),
    .rst        (rst),
    .we         (cnt_we),
    .waddr      (ch_addr),
    .wdata      (tc_clamped),
    .raddr      (ch_addr),
    .rdata      (tc_rdata),
    .clear_done (clear_done)
  );

  pcpa_coef_mem #(
    .ADDR_W (COEF_AW),
    .DEPTH  (COEF_DEPTH)
  ) u_coef_mem (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (item.coefficient),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  pcpa_mac u_mac (
    .clk   (clk),
    .ctrl  (mac_ctrl),
    .q_mag (q_mag),
    .coef  (coef_rdata),
    .acc   (mac_acc),
    .sat   (mac_sat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result.valid <= 1'b0;
    end else begin
      if (res_load) begin
        result.valid          <= 1'b1;
        result.aligned_charge <= mac_acc;
        result.saturated      <= mac_sat;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && (item.req_type == REQ_EVAL)) begin
            ch_q  <= ch_addr;
            q_neg <= item.charge[CHARGE_W-1];
            q_mag <= item.charge[CHARGE_W-1] ? CHARGE_W'(-item.charge)
                                             : CHARGE_W'(item.charge);
            state <= ch_ok ? S_COUNT : S_DONE;
          end
        end
        S_COUNT: begin
          if (tc_rdata == '0) begin
            state <= S_DONE;
          end else begin
            k     <= top_k;
            state <= S_LOAD;
          end
        end
        S_LOAD, S_ADD: begin
          if (k == '0) begin
            state <= S_DONE;
          end else begin
            k     <= k - TI_AW'(1);
            state <= S_MAG;
          end
        end
        S_MAG:  state <= S_MULH;
        S_MULH: state <= S_MULL;
        S_MULL: state <= S_COMB;
        S_COMB: state <= S_ADD;
        S_DONE: begin
          if (res_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_eval_blocks: assert property (@(posedge clk) disable iff (rst)
    accept && (item.req_type == REQ_EVAL) |=> !item.ready)
    else $error("evaluate word did not hold off the input");

  a_no_write_while_clearing: assert property (@(posedge clk) disable iff (rst)
    !clear_done |-> !cnt_we && !coef_we)
    else $error("memory write during the clearing sweep");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state) == S_DONE)
    else $error("result raised outside the done state");
`endif

endmodule

/* tb/per_channel_polynomial_alignment_unit_test.sv */
`timescale 1ns / 1ps

module per_channel_polynomial_alignment_unit_test;
  import pcpa_pkg::*;

  localparam int NUM_CH      = DEF_NUM_CHANNELS;
  localparam int MAX_TERMS   = DEF_MAX_TERMS;
  localparam int ITEM_TARGET = 1350;
  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_WAIT  = 40;
  localparam int MAX_REPORTS = 10;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]           req_type;
    logic [CHAN_W-1:0]          channel;
    logic [TIDX_W-1:0]          term_index;
    logic signed [COEF_W-1:0]   coefficient;
    logic [TCNT_W-1:0]          term_count;
    logic signed [CHARGE_W-1:0] charge;
  } pcpa_word_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] aligned_charge;
    logic                    saturated;
  } alignment_t;

  typedef struct packed {
    pcpa_word_t w;
    logic       typed;
    alignment_t res;
  } table_row_t;

  localparam alignment_t ZERO_RES = '{48'sd0, 1'b0};

  localparam table_row_t DIRECTED_ROWS [25] = '{
    '{'{REQ_EVAL,   10'd0,    2'd0, 32'sh0,        3'd0, 32'sh0},        1'b1, ZERO_RES},
    '{'{REQ_EVAL,   10'd1023, 2'd3, 32'shFFFFFFFF, 3'd7, 32'sh7FFFFFFF}, 1'b1, ZERO_RES},
    '{'{REQ_UNUSED, 10'd1023, 2'd3, 32'shFFFFFFFF, 3'd7, 32'shFFFFFFFF}, 1'b0, ZERO_RES},
    '{'{REQ_COEF,   10'd5,    2'd0, 32'sh7FFFFFFF, 3'd0, 32'sh0},        1'b0, ZERO_RES},
    '{'{REQ_COEF,   10'd5,    2'd1, 32'sh80000000, 3'd7, 32'sh0},        1'b0, ZERO_RES},
    '{'{REQ_COEF,   10'd5,    2'd2, 32'sh00010000, 3'd0, 32'sh0},        1'b0, ZERO_RES},
    '{'{REQ_COEF,   10'd5,    2'd3, 32'shFFFF0000, 3'd0, 32'sh0},        1'b0, ZERO_RES},
    '{'{REQ_COUNT,  10'd5,    2'd3, 32'shFFFFFFFF, 3'd1, 32'sh0},        1'b0, ZERO_RES},
    '{'{REQ_EVAL,   10'd5,    2'd0, 32'sh0,        3'd0, 32'sh80000000},
      1'b1, '{48'sh00007FFFFFFF, 1'b0}},
    '{'{REQ_COUNT,  10'd5,    2'd0, 32'sh0,        3'd7, 32'sh0},        1'b0, ZERO_RES},
    '{'{REQ_EVAL,   10'd5,    2'd0, 32'sh0,        3'd0, 32'sh7FFFFFFF}, 1'b0, ZERO_RES},
    '{'{REQ_EVAL,   10'd5,    2'd0, 32'sh0,        3'd0, 32'sh80000000}, 1'b0, ZERO_RES},
    '{'{REQ_EVAL,   10'd5,    2'd0, 32'sh0,        3'd0, 32'sh0},
      1'b1, '{48'sh00007FFFFFFF, 1'b0}},
    '{'{REQ_EVAL,   10'd5,    2'd0, 32'sh0,        3'd0, 32'sh00010000}, 1'b0, ZERO_RES},
    '{'{REQ_COUNT,  10'd5,    2'd0, 32'sh0,        3'd3, 32'sh0},        1'b0, ZERO_RES},
    '{'{REQ_EVAL,   10'd5,    2'd0, 32'sh0,        3'd0, 32'shFFFF0000}, 1'b0, ZERO_RES},
    '{'{REQ_COEF,   10'd1023, 2'd0, 32'sh7FFFFFFF, 3'd0, 32'sh0},        1'b0, ZERO_RES},
    '{'{REQ_COEF,   10'd1023, 2'd1, 32'sh7FFFFFFF, 3'd0, 32'sh0},        1'b0, ZERO_RES},
    '{'{REQ_COEF,   10'd1023, 2'd2, 32'sh7FFFFFFF, 3'd0, 32'sh0},        1'b0, ZERO_RES},
    '{'{REQ_COEF,   10'd1023, 2'd3, 32'sh7FFFFFFF, 3'd0, 32'sh0},        1'b0, ZERO_RES},
    '{'{REQ_COUNT,  10'd1023, 2'd0, 32'sh0,        3'd4, 32'sh0},        1'b0, ZERO_RES},
    '{'{REQ_EVAL,   10'd1023, 2'd0, 32'sh0,        3'd0, 32'sh7FFFFFFF},
      1'b1, '{ACC_MAX, 1'b1}},
    '{'{REQ_EVAL,   10'd1023, 2'd0, 32'sh0,        3'd0, 32'sh80000000},
      1'b1, '{ACC_MIN, 1'b1}},
    '{'{REQ_COUNT,  10'd5,    2'd0, 32'sh0,        3'd0, 32'sh0},        1'b0, ZERO_RES},
    '{'{REQ_EVAL,   10'd5,    2'd0, 32'sh0,        3'd0, 32'sh7FFFFFFF}, 1'b1, ZERO_RES}
  };

  logic clk;
  logic rst;

  pcpa_in_if  words_in ();
  pcpa_out_if words_out ();

  per_channel_polynomial_alignment_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (words_in),
    .result (words_out)
  );

  logic signed [COEF_W-1:0] coef_table [NUM_CH*MAX_TERMS];
  bit                       coef_written [NUM_CH*MAX_TERMS];
  logic [TCNT_W-1:0]        count_table [NUM_CH];
  alignment_t               pending_alignments [$];

  int  failures;
  int  words_sent;
  int  quiet_cycles = 0;
  bit  steady;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic alignment_t evaluate_poly(input logic [CHAN_W-1:0] ch,
                                               input logic signed [CHARGE_W-1:0] q);
    alignment_t        r;
    logic signed [95:0] acc;
    logic signed [95:0] q_wide;
    int                n;
    int                base;
    r = ZERO_RES;
    n = int'(count_table[ch]);
    base = int'(ch) * MAX_TERMS;
    q_wide = q;
    if (n == 0) return r;
    acc = coef_table[base + n - 1];
    for (int k = n - 2; k >= 0; k--) begin
      acc = (acc * q_wide) / 96'sd65536 + coef_table[base + k];
      if (acc > ACC_MAX) begin
        acc = ACC_MAX;
        r.saturated = 1'b1;
      end else if (acc < ACC_MIN) begin
        acc = ACC_MIN;
        r.saturated = 1'b1;
      end
    end
    r.aligned_charge = acc[ACC_W-1:0];
    return r;
  endfunction

  task automatic take_word(input pcpa_word_t w, input logic typed, input alignment_t typed_res);
    int         idx;
    alignment_t due;
    idx = int'(w.channel) * MAX_TERMS + int'(w.term_index);
    case (w.req_type)
      REQ_COEF: begin
        coef_table[idx] = w.coefficient;
        coef_written[idx] = 1'b1;
      end
      REQ_COUNT: begin
        count_table[w.channel] = (w.term_count > MAX_TERMS) ? TCNT_W'(MAX_TERMS) : w.term_count;
      end
      REQ_EVAL: begin
        due = typed ? typed_res : evaluate_poly(w.channel, w.charge);
        pending_alignments = {pending_alignments, due};
      end
      default: ;
    endcase
  endtask

  // A term count never reaches past the coefficients already written for its channel.
  function automatic logic [TCNT_W-1:0] safe_count(input logic [CHAN_W-1:0] ch,
                                                   input logic [TCNT_W-1:0] tc);
    int filled;
    int used;
    filled = 0;
    while (filled < MAX_TERMS && coef_written[int'(ch) * MAX_TERMS + filled]) filled++;
    used = (tc > MAX_TERMS) ? MAX_TERMS : int'(tc);
    if (used <= filled) return tc;
    return TCNT_W'(filled);
  endfunction

  function automatic logic signed [31:0] pick_q16();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
      2: begin
        case ($urandom_range(0, 4))
          0: return 32'sh7FFFFFFF;
          1: return 32'sh80000000;
          2: return 32'sh0;
          3: return 32'shFFFF0000;
          default: return 32'sh00010000;
        endcase
      end
      default: return ($urandom_range(0, 1) ? 32'h10000 : 32'hFFFF0000)
                      + $urandom_range(0, 32'h1FFF) - 32'h1000;
    endcase
  endfunction

  function automatic logic [CHAN_W-1:0] pick_channel();
    logic [CHAN_W-1:0] pool [8];
    pool = '{10'd0, 10'd1, 10'd2, 10'd5, 10'd511, 10'd512, 10'd1022, 10'd1023};
    if ($urandom_range(0, 3) == 0) return CHAN_W'($urandom);
    return pool[$urandom_range(0, 7)];
  endfunction

  function automatic pcpa_word_t scrambled_word();
    pcpa_word_t w;
    w.req_type    = REQ_W'($urandom);
    w.channel     = CHAN_W'($urandom);
    w.term_index  = TIDX_W'($urandom);
    w.coefficient = $urandom;
    w.term_count  = TCNT_W'($urandom);
    w.charge      = $urandom;
    return w;
  endfunction

  task automatic send_word(input pcpa_word_t w, input logic typed, input alignment_t typed_res);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap > 0) begin
      words_in.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    words_in.valid       <= 1'b1;
    words_in.req_type    <= w.req_type;
    words_in.channel     <= w.channel;
    words_in.term_index  <= w.term_index;
    words_in.coefficient <= w.coefficient;
    words_in.term_count  <= w.term_count;
    words_in.charge      <= w.charge;
    @(posedge clk);
    while (words_in.ready !== 1'b1) @(posedge clk);
    take_word(w, typed, typed_res);
    if (w.req_type != REQ_UNUSED) words_sent++;
  endtask

  task automatic run_sequence();
    pcpa_word_t        w;
    logic [CHAN_W-1:0] ch;
    int                first;
    int                writes;
    int                evals;
    ch = pick_channel();
    first = $urandom_range(0, MAX_TERMS - 1);
    writes = ($urandom_range(0, 3) != 0) ? MAX_TERMS : $urandom_range(0, MAX_TERMS);
    for (int j = 0; j < writes; j++) begin
      w = scrambled_word();
      w.req_type    = REQ_COEF;
      w.channel     = ch;
      w.term_index  = TIDX_W'((first + j) % MAX_TERMS);
      w.coefficient = pick_q16();
      send_word(w, 1'b0, ZERO_RES);
    end
    w = scrambled_word();
    w.req_type   = REQ_COUNT;
    w.channel    = ch;
    w.term_count = safe_count(ch, TCNT_W'($urandom_range(0, 7)));
    send_word(w, 1'b0, ZERO_RES);
    evals = $urandom_range(1, 6);
    for (int j = 0; j < evals; j++) begin
      w = scrambled_word();
      w.req_type = REQ_EVAL;
      w.channel  = ch;
      w.charge   = pick_q16();
      send_word(w, 1'b0, ZERO_RES);
    end
  endtask

  task automatic send_noise();
    pcpa_word_t w;
    w = scrambled_word();
    if ($urandom_range(0, 1) == 0) w.channel = pick_channel();
    if (w.req_type == REQ_COUNT) w.term_count = safe_count(w.channel, w.term_count);
    if (w.req_type == REQ_COEF || w.req_type == REQ_EVAL) begin
      w.coefficient = pick_q16();
      w.charge      = pick_q16();
    end
    send_word(w, 1'b0, ZERO_RES);
  endtask

  task automatic note_failure(input string what);
    failures++;
    if (failures <= MAX_REPORTS) $display("%s", what);
  endtask

  initial begin : stimulus
    rst                  = 1'b1;
    steady               = 1'b0;
    failures             = 0;
    words_sent           = 0;
    words_in.valid       = 1'b0;
    words_in.req_type    = REQ_EVAL;
    words_in.channel     = '0;
    words_in.term_index  = '0;
    words_in.coefficient = '0;
    words_in.term_count  = '0;
    words_in.charge      = '0;
    foreach (coef_table[i]) begin
      coef_table[i]   = '0;
      coef_written[i] = 1'b0;
    end
    foreach (count_table[i]) count_table[i] = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[i]) send_word(DIRECTED_ROWS[i].w, DIRECTED_ROWS[i].typed,
                                         DIRECTED_ROWS[i].res);

    while (words_sent < ITEM_TARGET) begin
      steady = ($urandom_range(0, 6) == 0);
      if ($urandom_range(0, 9) < 7) run_sequence();
      else repeat ($urandom_range(1, 4)) send_noise();
    end

    @(negedge clk);
    words_in.valid <= 1'b0;
    while (pending_alignments.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (failures == 0) begin
      $display("per_channel_polynomial_alignment_unit_test OK");
    end else begin
      $display("per_channel_polynomial_alignment_unit_test NOT OK");
    end
    $finish;
  end

  initial begin : result_acceptor
    int gap;
    words_out.ready = 1'b0;
    @(negedge clk);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        words_out.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      words_out.ready <= 1'b1;
      @(posedge clk);
      while (words_out.valid !== 1'b1) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    alignment_t want;
    if (!rst && words_out.valid === 1'b1 && words_out.ready === 1'b1) begin
      if (pending_alignments.size() == 0) begin
        note_failure($sformatf("unexpected result word: aligned_charge %0d saturated %0b",
                               words_out.aligned_charge, words_out.saturated));
      end else begin
        want = pending_alignments.pop_front();
        if (words_out.aligned_charge !== want.aligned_charge ||
            words_out.saturated !== want.saturated) begin
          note_failure($sformatf(
            "mismatch: aligned_charge %0d saturated %0b, expected %0d saturated %0b",
            words_out.aligned_charge, words_out.saturated,
            want.aligned_charge, want.saturated));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((words_in.valid === 1'b1 && words_in.ready === 1'b1) ||
        (words_out.valid === 1'b1 && words_out.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("per_channel_polynomial_alignment_unit_test NOT OK");
      $finish;
    end
  end

endmodule

/* filelist.f */
sv/pcpa_pkg.sv
sv/pcpa_if.sv
sv/pcpa_coef_mem.sv
sv/pcpa_count_mem.sv
sv/pcpa_mac.sv
sv/per_channel_polynomial_alignment_unit.sv
tb/per_channel_polynomial_alignment_unit_test.sv
